@@ rtl/mopd_pkg.sv @@
// Shared types and constants for the min-OR-path search block.
// Used by mopd_engine and by the top level; depends on nothing.
package mopd_pkg;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_WEIGHT_BITS = 16;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_ADD,
        ST_INIT,
        ST_RELAX,
        ST_ROUND,
        ST_DONE
    } eng_state_t;

    // Top level to engine.
    typedef struct packed {
        logic start;
        logic out_free;
        cmd_t cmd;
    } eng_ctl_t;

    // Engine to top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

endpackage

@@ rtl/mopd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module mopd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mopd_engine.sv @@
// Command sequencer and search datapath around the edge and node memories.
// Depends on mopd_pkg and mopd_ram.
module mopd_engine #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mopd_pkg::eng_ctl_t                  ctl,
    input  logic [$clog2(MAX_NODES+1)-1:0]      nn,
    input  logic [$clog2(MAX_NODES)-1:0]        node_a,
    input  logic [$clog2(MAX_NODES)-1:0]        node_b,
    input  logic [WEIGHT_BITS-1:0]              weight,
    output mopd_pkg::eng_stat_t                 stat,
    output logic [WEIGHT_BITS-1:0]              path_cost,
    output logic                                reachable
);

    import mopd_pkg::*;

    localparam int NB    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int WB    = WEIGHT_BITS;
    localparam int EDGES = MAX_NODES * MAX_NODES;
    localparam int EAW   = $clog2(EDGES);
    localparam int EW    = WB + 1;
    localparam int NW    = WB + 2;

    // Node word: {settled, cost}; cost has an extra top bit that marks unreached.
    localparam logic [WB:0] UNREACHED = {1'b1, {WB{1'b0}}};

    eng_state_t state_reg, state_next;

    logic [EAW-1:0] wipe_reg, wipe_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           rd_pending_reg, rd_pending_next;
    logic [NB-1:0]  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]  nn_reg, nn_next;
    logic [NB-1:0]  a_reg, a_next;
    logic [NB-1:0]  b_reg, b_next;
    logic [WB-1:0]  w_reg, w_next;
    logic [EAW-1:0] eaddr_reg, eaddr_next;
    logic [NB-1:0]  best_reg, best_next;
    logic [WB-1:0]  best_cost_reg, best_cost_next;
    logic [EAW-1:0] base_reg, base_next;
    logic           found_reg, found_next;
    logic [NB-1:0]  min_idx_reg, min_idx_next;
    logic [WB-1:0]  min_cost_reg, min_cost_next;
    logic [WB:0]    tgt_cost_reg, tgt_cost_next;

    logic           edge_we;
    logic [EAW-1:0] edge_waddr, edge_raddr;
    logic [EW-1:0]  edge_wdata, edge_rdata;
    logic           node_we;
    logic [NB-1:0]  node_waddr, node_raddr;
    logic [NW-1:0]  node_wdata, node_rdata;

    logic [EAW-1:0] in_addr;
    logic           in_range, query_ok;
    logic           ed_valid;
    logic [WB-1:0]  ed_w;
    logic           nd_settled;
    logic [WB:0]    nd_cost, cand, new_cost;
    logic           is_best, relax, new_settled, take_min;
    logic           issue, pass_last, init_last, wipe_last, add_write;

    mopd_ram #(.WIDTH(EW), .DEPTH(EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    mopd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Decode and the relaxation step on the data returned by the memories.
    always_comb
    begin
        in_addr   = EAW'(node_a) * EAW'(MAX_NODES) + EAW'(node_b);
        in_range  = (CW'(node_a) < CW'(MAX_NODES)) && (CW'(node_b) < CW'(MAX_NODES));
        query_ok  = (CW'(node_a) < nn) && (CW'(node_b) < nn);

        ed_valid   = edge_rdata[WB];
        ed_w       = edge_rdata[WB-1:0];
        nd_settled = node_rdata[WB+1];
        nd_cost    = node_rdata[WB:0];
        cand       = {1'b0, ed_w | best_cost_reg};

        is_best     = (rd_idx_reg == best_reg);
        relax       = !nd_settled && ed_valid && (nd_cost > cand) && !is_best;
        new_settled = nd_settled | is_best;
        new_cost    = relax ? cand : nd_cost;
        take_min    = rd_pending_reg && !new_settled && !new_cost[WB]
                      && (!found_reg || (min_cost_reg > new_cost[WB-1:0]));

        issue     = (state_reg == ST_RELAX) && (idx_reg < nn_reg);
        pass_last = rd_pending_reg && (CW'(rd_idx_reg) == nn_reg - CW'(1));
        init_last = (idx_reg == nn_reg - CW'(1));
        wipe_last = (wipe_reg == EAW'(EDGES - 1));
        add_write = !ed_valid || (ed_w > w_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WIPE:
            begin
                if (wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    case (ctl.cmd)
                        CMD_ADD:   state_next = in_range ? ST_ADD : ST_IDLE;
                        CMD_CLEAR: state_next = ST_WIPE;
                        CMD_QUERY: state_next = query_ok ? ST_INIT : ST_DONE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:   state_next = ST_IDLE;
            ST_INIT:
            begin
                if (init_last)
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (pass_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = found_reg ? ST_RELAX : ST_DONE;
            ST_DONE:
            begin
                if (ctl.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory controls and outputs.
    always_comb
    begin
        edge_raddr = (state_reg == ST_IDLE) ? in_addr
                                            : base_reg + EAW'(idx_reg[NB-1:0]);
        edge_we    = (state_reg == ST_WIPE) || ((state_reg == ST_ADD) && add_write);
        edge_waddr = (state_reg == ST_WIPE) ? wipe_reg : eaddr_reg;
        edge_wdata = (state_reg == ST_WIPE) ? '0 : {1'b1, w_reg};

        node_raddr = idx_reg[NB-1:0];
        node_we    = (state_reg == ST_INIT) || ((state_reg == ST_RELAX) && rd_pending_reg);
        if (state_reg == ST_INIT)
        begin
            node_waddr = idx_reg[NB-1:0];
            node_wdata = {1'b0, (idx_reg[NB-1:0] == a_reg) ? {(WB+1){1'b0}} : UNREACHED};
        end
        else
        begin
            node_waddr = rd_idx_reg;
            node_wdata = {new_settled, new_cost};
        end

        stat.idle      = (state_reg == ST_IDLE);
        stat.res_valid = (state_reg == ST_DONE);
        reachable      = !tgt_cost_reg[WB];
        path_cost      = tgt_cost_reg[WB] ? '0 : tgt_cost_reg[WB-1:0];
    end

    // Datapath register updates.
    always_comb
    begin
        wipe_next       = wipe_reg;
        idx_next        = idx_reg;
        rd_pending_next = 1'b0;
        rd_idx_next     = rd_idx_reg;
        nn_next         = nn_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        eaddr_next      = eaddr_reg;
        best_next       = best_reg;
        best_cost_next  = best_cost_reg;
        base_next       = base_reg;
        found_next      = found_reg;
        min_idx_next    = min_idx_reg;
        min_cost_next   = min_cost_reg;
        tgt_cost_next   = tgt_cost_reg;

        case (state_reg)
            ST_WIPE:
            begin
                wipe_next = wipe_reg + EAW'(1);
            end
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    nn_next       = nn;
                    a_next        = node_a;
                    b_next        = node_b;
                    w_next        = weight;
                    eaddr_next    = in_addr;
                    idx_next      = '0;
                    wipe_next     = '0;
                    tgt_cost_next = UNREACHED;
                end
            end
            ST_INIT:
            begin
                idx_next = idx_reg + CW'(1);
                if (init_last)
                begin
                    idx_next       = '0;
                    best_next      = a_reg;
                    best_cost_next = '0;
                    base_next      = EAW'(a_reg) * EAW'(MAX_NODES);
                    found_next     = 1'b0;
                end
            end
            ST_RELAX:
            begin
                if (issue)
                begin
                    idx_next        = idx_reg + CW'(1);
                    rd_pending_next = 1'b1;
                    rd_idx_next     = idx_reg[NB-1:0];
                end
                if (take_min)
                begin
                    found_next    = 1'b1;
                    min_idx_next  = rd_idx_reg;
                    min_cost_next = new_cost[WB-1:0];
                end
                if (rd_pending_reg && (rd_idx_reg == b_reg))
                begin
                    tgt_cost_next = new_cost;
                end
            end
            ST_ROUND:
            begin
                if (found_reg)
                begin
                    best_next      = min_idx_reg;
                    best_cost_next = min_cost_reg;
                    base_next      = EAW'(min_idx_reg) * EAW'(MAX_NODES);
                    found_next     = 1'b0;
                    idx_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_WIPE;
            wipe_reg       <= '0;
            idx_reg        <= '0;
            rd_pending_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wipe_reg       <= wipe_next;
            idx_reg        <= idx_next;
            rd_pending_reg <= rd_pending_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        nn_reg        <= nn_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        eaddr_reg     <= eaddr_next;
        best_reg      <= best_next;
        best_cost_reg <= best_cost_next;
        base_reg      <= base_next;
        min_idx_reg   <= min_idx_next;
        min_cost_reg  <= min_cost_next;
        tgt_cost_reg  <= tgt_cost_next;
    end

    // The node write-back of one entry never meets a read of the same entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && node_we) |-> (node_waddr != node_raddr))
        else $error("node memory read and write collide");

    // The next node to settle is never the one settled in this round.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ROUND) && found_reg) |-> (min_idx_reg != best_reg))
        else $error("settled node chosen again");

    // The edge store is only written by the clearing sweep or an edge load.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_we |-> ((state_reg == ST_WIPE) || (state_reg == ST_ADD)))
        else $error("stray edge memory write");

    // A relaxation pass never leaves a read in flight when the engine goes idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !rd_pending_reg)
        else $error("read pending while idle");

endmodule

@@ rtl/min_or_path_dijkstra_unit.sv @@
// Top level of the min-OR-path graph search block: stream ports, node count
// register and result register. Depends on mopd_pkg and mopd_engine.
//
// Usage. Commands arrive as beats on the slave stream: s_tuser carries the
// command (add edge, run query, clear graph), s_tdata the two node numbers
// and the weight. An add-edge beat writes one entry of the adjacency matrix,
// keeping the smaller weight when the edge already exists. A clear beat
// invalidates every edge. A query beat searches from node_a and returns one
// beat on the master stream: the least OR-combined path cost to node_b in
// m_tdata and the reachable flag in m_tuser (cost reads zero when the flag
// is low). Only queries produce result beats.
//
// Timing. The block works on one command at a time; s_tready is high only
// while the engine is idle. An add edge is a read-modify-write of the edge
// memory. A clear writes one edge entry per cycle. A query with n nodes in
// use first initialises the n node entries, then runs one round for the
// source and one for each further node that it reaches: every round makes
// one pass over the node memory and one row of the edge memory, one entry
// per cycle. The edge memory read port sets this pace.
//
// Reset runs the same clearing sweep over the edge memory, so s_tready
// stays low until the sweep ends; the node count register can be
// written during that time and resets to MAX_NODES. The result sits in an
// output register: when the receiver stalls, the engine holds its finished
// query until the register frees up, and new commands wait behind it.
module min_or_path_dijkstra_unit #(
    parameter int MAX_NODES   = mopd_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = mopd_pkg::DEF_WEIGHT_BITS
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // node_a, node_b, weight; zero padded to whole bytes
    input  logic [((2*$clog2(MAX_NODES)+WEIGHT_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic [1:0] s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // path_cost; zero padded to whole bytes
    output logic [((WEIGHT_BITS+7)/8)*8-1:0] m_tdata,
    // reachable
    output logic [0:0] m_tuser,

    input  logic                               cfg_we,
    input  logic [$clog2(MAX_NODES+1)-1:0]     cfg_wdata
);

    import mopd_pkg::*;

    localparam int NB    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int WB    = WEIGHT_BITS;
    localparam int OUT_W = ((WB + 7) / 8) * 8;

    logic [CW-1:0]  node_count_reg;
    logic [CW-1:0]  nn;
    eng_ctl_t       ctl;
    eng_stat_t      stat;
    logic [NB-1:0]  node_a, node_b;
    logic [WB-1:0]  weight;
    logic [WB-1:0]  eng_cost;
    logic           eng_reach;
    logic           out_free;
    logic           m_tvalid_reg;
    logic [WB-1:0]  m_cost_reg;
    logic           m_reach_reg;

    // Unpack the command beat, lowest field first.
    assign node_a = s_tdata[NB-1:0];
    assign node_b = s_tdata[2*NB-1:NB];
    assign weight = s_tdata[2*NB+WB-1:2*NB];

    // A node count of zero behaves as one node; anything past the matrix
    // size saturates to the full matrix.
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            nn = CW'(1);
        end
        else if (node_count_reg > CW'(MAX_NODES))
        begin
            nn = CW'(MAX_NODES);
        end
        else
        begin
            nn = node_count_reg;
        end
    end

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_tready     = stat.idle;
    assign ctl.start    = s_tvalid && stat.idle;
    assign ctl.out_free = out_free;
    assign ctl.cmd      = cmd_t'(s_tuser);

    mopd_engine #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .nn        (nn),
        .node_a    (node_a),
        .node_b    (node_b),
        .weight    (weight),
        .stat      (stat),
        .path_cost (eng_cost),
        .reachable (eng_reach)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CW'(MAX_NODES);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (stat.res_valid && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid && out_free)
        begin
            m_cost_reg  <= eng_cost;
            m_reach_reg <= eng_reach;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = OUT_W'(m_cost_reg);
    assign m_tuser[0] = m_reach_reg;

    // An unreachable target always reports a zero cost.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("nonzero cost on unreachable result");

    // Commands are never taken while a finished query waits inside the engine.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.res_valid |-> !s_tready)
        else $error("command accepted with a result pending");

    // A result leaves the engine only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && m_tvalid_reg && !m_tready) |=> stat.res_valid)
        else $error("result dropped while the receiver stalls");

endmodule

@@ test/mopd_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the min-OR-path search block: watches the command stream,
// the result stream and the node count port, and predicts every result.
// Depends on mopd_pkg for the command codes and the default sizes.
module mopd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          reached
);

    import mopd_pkg::*;

    localparam int NODES = DEF_MAX_NODES;
    localparam logic [16:0] UNREACHED = 17'h10000;

    typedef struct packed {
        logic [15:0] cost;
        logic        reach;
    } path_res_t;

    logic [6:0]  node_count = 7'd64;
    logic [15:0] edge_w [NODES*NODES];
    bit          edge_v [NODES*NODES];
    path_res_t   path_q [$];
    int          errs = 0;
    int          n_checked = 0;
    int          n_reached = 0;

    function automatic int active_nodes(logic [6:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > NODES)
            return NODES;
        return cnt;
    endfunction

    // Greedy search where a path costs the OR of its weights; ties go to
    // the lowest node index.
    function automatic path_res_t min_or_path(int nn, int src, int dst);
        logic [16:0] cost [NODES];
        bit          done [NODES];
        path_res_t   res;
        int          best;
        logic [16:0] best_cost;
        logic [15:0] cand;
        res = '0;
        if (src >= nn || dst >= nn)
            return res;
        for (int i = 0; i < NODES; i++)
        begin
            cost[i] = UNREACHED;
            done[i] = 1'b0;
        end
        cost[src] = '0;
        for (int r = 0; r < nn; r++)
        begin
            best = -1;
            best_cost = '0;
            for (int i = 0; i < nn; i++)
                if (!done[i] && cost[i] != UNREACHED && (best < 0 || best_cost > cost[i]))
                begin
                    best = i;
                    best_cost = cost[i];
                end
            if (best < 0)
                break;
            done[best] = 1'b1;
            for (int i = 0; i < nn; i++)
                if (!done[i] && edge_v[best*NODES+i])
                begin
                    cand = edge_w[best*NODES+i] | best_cost[15:0];
                    if (cost[i] > {1'b0, cand})
                        cost[i] = {1'b0, cand};
                end
        end
        if (cost[dst] != UNREACHED)
        begin
            res.cost  = cost[dst][15:0];
            res.reach = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        path_res_t   want;
        path_res_t   got;
        int          idx;
        logic [5:0]  na;
        logic [5:0]  nb;
        logic [15:0] wt;
        if (!rst_n)
        begin
            node_count = 7'd64;
            for (int i = 0; i < NODES*NODES; i++)
            begin
                edge_v[i] = 1'b0;
                edge_w[i] = '0;
            end
            path_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.cost  = m_tdata;
                got.reach = m_tuser[0];
                if (path_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, cost %h reachable %b",
                             $time, got.cost, got.reach);
                    errs++;
                end
                else
                begin
                    want = path_q.pop_front();
                    n_checked++;
                    if (got.reach === 1'b1)
                        n_reached++;
                    if (got.cost !== want.cost)
                    begin
                        $display("%0t: path_cost mismatch, expected %h actual %h",
                                 $time, want.cost, got.cost);
                        errs++;
                    end
                    if (got.reach !== want.reach)
                    begin
                        $display("%0t: reachable mismatch, expected %b actual %b",
                                 $time, want.reach, got.reach);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                na = s_tdata[5:0];
                nb = s_tdata[11:6];
                wt = s_tdata[27:12];
                case (cmd_t'(s_tuser))
                    CMD_ADD:
                    begin
                        idx = na * NODES + nb;
                        if (!edge_v[idx] || edge_w[idx] > wt)
                        begin
                            edge_w[idx] = wt;
                            edge_v[idx] = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                        for (int i = 0; i < NODES*NODES; i++)
                            edge_v[i] = 1'b0;
                    CMD_QUERY:
                        path_q.push_back(min_or_path(active_nodes(node_count), na, nb));
                    default:
                        ;
                endcase
            end
            if (cfg_we)
                node_count = cfg_wdata;
        end
        fail_count <= errs;
        pending    <= path_q.size();
        checked    <= n_checked;
        reached    <= n_reached;
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the min-OR-path search testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on mopd_pkg, the block and
// mopd_checker, which does all prediction and comparison.
module tb_top;
    import mopd_pkg::*;

    // The longest legal quiet stretch is a full 64-node query or a clear
    // sweep plus a stalled receiver, and the limit leaves a wide margin over
    // that as a bound for a hung block.
    localparam int QUIET_LIMIT = 50000;
    // Cycles to let an add or clear finish when no result marks its end.
    localparam int SETTLE_CYCLES = 4200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // node_a [5:0], node_b [11:6], weight [27:12], zero padding [31:28]
    logic [31:0] s_tdata = '0;
    // cmd
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // path_cost [15:0]
    logic [15:0] m_tdata;
    // reachable
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;
    int reached;

    // Idle and stall odds in percent, changed per phase.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    int quiet_cycles = 0;
    int n_add = 0;
    int n_query = 0;
    int n_clear = 0;
    int n_unused = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    min_or_path_dijkstra_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mopd_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .reached    (reached)
    );

    // The receiver draws a fresh ready every cycle, so stalls of any length
    // land on every phase of the engine's work.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Watchdog: any cycle without a beat on either stream counts as quiet.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one command beat and hold it until the block takes it. The
    // valid is only dropped on a cycle that really idles, so back-to-back
    // beats keep it high without a second assignment in the same step.
    task automatic push_command(input cmd_t c, input logic [5:0] na, input logic [5:0] nb,
                                input logic [15:0] wt);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, wt, nb, na};
        s_tuser  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (c)
            CMD_ADD:   n_add++;
            CMD_QUERY: n_query++;
            CMD_CLEAR: n_clear++;
            default:   n_unused++;
        endcase
    endtask

    // Stop sending and wait until every query has answered. The first edge
    // lets the scoreboard count a query accepted on the last handshake.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Full drain: results first, then room for a trailing add or clear.
    task automatic quiesce();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [6:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Most endpoints come from a few low nodes so that edges chain into
    // real paths; the rest spread over the active range and beyond it.
    function automatic logic [5:0] pick_node(input int nn);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 6'($urandom_range((nn < 10 ? nn : 10) - 1));
        if (roll < 85)
            return 6'($urandom_range(nn - 1));
        return 6'($urandom_range(63));
    endfunction

    // Sparse weights make the OR cost differ between routes; full-width
    // values exercise every bit.
    function automatic logic [15:0] pick_weight();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 16'($urandom_range(65535));
        if (roll < 70)
            return 16'd1 << $urandom_range(15);
        return 16'($urandom_range(15));
    endfunction

    // One random phase: a fresh graph under one node count and one idle mix.
    // Adds dominate so queries find real paths; clears and the unused code
    // turn up now and then as noise.
    task automatic random_phase(input logic [6:0] cfg_val, input int count,
                                input int src_pct, input int sink_pct, input bit mid_pause);
        int nn;
        int roll;
        quiesce();
        write_node_count(cfg_val);
        nn = (cfg_val == 0) ? 1 : ((cfg_val > 64) ? 64 : cfg_val);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        push_command(CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     16'($urandom_range(65535)));
        for (int n = 0; n < count; n++)
        begin
            // Hold the sender back once until every answer is in.
            if (mid_pause && n == count / 2)
                wait_for_results();
            roll = $urandom_range(99);
            if (roll < 55)
                push_command(CMD_ADD, pick_node(nn), pick_node(nn), pick_weight());
            else if (roll < 92)
                push_command(CMD_QUERY, pick_node(nn), pick_node(nn),
                             16'($urandom_range(65535)));
            else if (roll < 95)
                push_command(CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
                             16'($urandom_range(65535)));
            else
                push_command(CMD_NONE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                             16'($urandom_range(65535)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A node count of zero behaves as a single node: a query to itself
        // is reachable at cost zero, anything else is out of range.
        write_node_count(7'd0);
        push_command(CMD_QUERY, 6'd0, 6'd0, 16'hFFFF);
        push_command(CMD_QUERY, 6'd1, 6'd1, 16'h0000);

        // A count above the maximum saturates to 64 nodes. Duplicate edges
        // keep the smaller weight, and two routes to node 63 compete on
        // their OR cost.
        quiesce();
        write_node_count(7'd127);
        push_command(CMD_ADD, 6'd0, 6'd1, 16'hFFFF);
        push_command(CMD_ADD, 6'd0, 6'd1, 16'h0003);
        push_command(CMD_ADD, 6'd0, 6'd1, 16'h0005);
        push_command(CMD_ADD, 6'd1, 6'd63, 16'h0100);
        push_command(CMD_ADD, 6'd0, 6'd2, 16'h0001);
        push_command(CMD_ADD, 6'd2, 6'd63, 16'h0100);
        push_command(CMD_ADD, 6'd63, 6'd0, 16'hFFFF);
        push_command(CMD_QUERY, 6'd0, 6'd63, 16'h0000);
        push_command(CMD_QUERY, 6'd63, 6'd1, 16'h0000);
        // A zero-weight edge gives a reachable target at cost zero, while
        // the reverse direction has no path at all.
        push_command(CMD_ADD, 6'd5, 6'd6, 16'h0000);
        push_command(CMD_QUERY, 6'd5, 6'd6, 16'h0000);
        push_command(CMD_QUERY, 6'd6, 6'd5, 16'h0000);
        push_command(CMD_QUERY, 6'd10, 6'd10, 16'h0000);
        push_command(CMD_NONE, 6'd63, 6'd63, 16'hFFFF);

        // With four nodes the route through node 50 is stored but hidden,
        // and an endpoint past the count answers unreachable.
        quiesce();
        write_node_count(7'd4);
        push_command(CMD_QUERY, 6'd0, 6'd2, 16'h0000);
        push_command(CMD_QUERY, 6'd0, 6'd63, 16'h0000);
        push_command(CMD_ADD, 6'd2, 6'd50, 16'h0010);
        push_command(CMD_ADD, 6'd50, 6'd3, 16'h0020);
        push_command(CMD_QUERY, 6'd2, 6'd3, 16'h0000);

        // Back at 64 nodes the hidden route takes part; a clear then
        // removes every edge.
        quiesce();
        write_node_count(7'd64);
        push_command(CMD_QUERY, 6'd2, 6'd3, 16'h0000);
        push_command(CMD_CLEAR, 6'd0, 6'd0, 16'h0000);
        push_command(CMD_QUERY, 6'd0, 6'd63, 16'h0000);

        random_phase(7'd8,   29, 0,  0,  1'b0);
        random_phase(7'd12,  29, 86, 0,  1'b1);
        random_phase(7'd127, 29, 0,  86, 1'b0);
        random_phase(7'd5,   29, 36, 36, 1'b0);

        quiesce();
        $display("Sent %0d commands: %0d add, %0d query, %0d clear, %0d unused code.",
                 n_add + n_query + n_clear + n_unused, n_add, n_query, n_clear, n_unused);
        $display("Checked %0d results (%0d reachable) over node counts 0 to 127.",
                 checked, reached);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mopd_pkg.sv
rtl/mopd_ram.sv
rtl/mopd_engine.sv
rtl/min_or_path_dijkstra_unit.sv
test/mopd_checker.sv
test/tb_top.sv
